/* hw/rtl/serial_command_matcher_event_fifo_macros.svh */
// Assertion helpers used by the RTL of the command matcher.
// Every macro samples on clock and is disabled while reset is high.
`ifndef SERIAL_COMMAND_MATCHER_EVENT_FIFO_MACROS_SVH
`define SERIAL_COMMAND_MATCHER_EVENT_FIFO_MACROS_SVH

// Same-cycle implication.
`define SCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/scm_pkg.sv */
package scm_pkg;

   localparam int WORD_COUNT   = 4;
   localparam int WORD_MAX_LEN = 11;

   localparam logic       KIND_BYTE   = 1'b0;
   localparam logic       KIND_POP    = 1'b1;
   localparam logic       RESULT_LINE = 1'b0;
   localparam logic       RESULT_POP  = 1'b1;
   localparam logic [7:0] LINE_END    = 8'h2E;

   localparam logic [2:0] CODE_NONE = 3'd0;
   localparam logic [2:0] CODE_UART = 3'd1;
   localparam logic [2:0] CODE_LCD  = 3'd2;
   localparam logic [2:0] CODE_TEMP = 3'd3;
   localparam logic [2:0] CODE_FREQ = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic       result_kind;
      logic [2:0] event_code;
      logic       taken;
   } rsp_payload_type;

   // Line matcher status towards the FIFO side.
   typedef struct packed {
      logic       done;
      logic [2:0] code;
   } line_status_type;

   localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAX_LEN] = '{
      '{"t", "a", "s", "k", ":", " ", "u", "a", "r", "t", "."},
      '{"t", "a", "s", "k", ":", " ", "l", "c", "d", ".", 8'h00},
      '{"t", "a", "s", "k", ":", " ", "t", "e", "m", "p", "."},
      '{"t", "a", "s", "k", ":", " ", "f", "r", "e", ".", 8'h00}
   };

   localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{4'd11, 4'd10, 4'd11, 4'd10};

   localparam logic [2:0] WORD_CODE [WORD_COUNT] =
      '{CODE_UART, CODE_LCD, CODE_TEMP, CODE_FREQ};

   function automatic logic [7:0] word_char(input logic [1:0] w, input logic [3:0] p);
      logic [7:0] c;
      c = 8'h00;
      if (p < 4'(WORD_MAX_LEN)) begin
         c = WORD_TEXT[w][p];
      end
      return c;
   endfunction

endpackage

/* hw/rtl/serial_command_matcher_event_fifo.sv */
// Channel | Ports                             | Direction | Moves
// req     | req_valid, req_ready, req_data    | in        | byte or pop request
// rsp     | rsp_valid, rsp_ready, rsp_data    | out       | line result or pop answer
//
// One request per cycle while rsp is not stalled. The accepting edge loads the input
// register, where the request is matched/queued; its result is then registered in
// the output register, which drives rsp_valid.
// Synchronous active-high reset clears pointers, line state and valids; the
// event store is not cleared and needs no clearing pass.
// A stalled rsp holds the input register (even a byte with no result); req_ready drops only then.
module serial_command_matcher_event_fifo
   import scm_pkg::*;
#(
   parameter int LINE_SLOTS  = 64,
   parameter int QUEUE_SLOTS = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int QW = $clog2(QUEUE_SLOTS);

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   // ring pointers; one slot kept free to tell full from empty
   logic [QW-1:0]   rd_ptr_ff, rd_ptr_in, rd_ptr_next;
   logic [QW-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [2:0]      event_slots [QUEUE_SLOTS];

   logic            advance, is_pop, line_step, empty, full, push_en, pop_en;
   line_status_type line_stat;

   // the stage moves whenever the output register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign is_pop    = (in_data_ff.kind == KIND_POP);
   assign line_step = advance && !is_pop;

   assign rd_ptr_next = (rd_ptr_ff == QW'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_ff + QW'(1);
   assign wr_ptr_next = (wr_ptr_ff == QW'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_ff + QW'(1);
   assign empty       = (rd_ptr_ff == wr_ptr_ff);
   assign full        = (wr_ptr_next == rd_ptr_ff);

   scm_line #(
      .LINE_SLOTS(LINE_SLOTS)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .step    (line_step),
      .rx_byte (in_data_ff.rx_byte),
      .status  (line_stat)
   );

   // a matched word is dropped, not queued, when the ring is full
   assign push_en = line_step && line_stat.done && (line_stat.code != CODE_NONE) && !full;
   assign pop_en  = advance && is_pop && !empty;

   assign rd_ptr_in   = pop_en  ? rd_ptr_next : rd_ptr_ff;
   assign wr_ptr_in   = push_en ? wr_ptr_next : wr_ptr_ff;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_comb begin
      priority if (advance) begin
         rsp_valid_in = is_pop || line_stat.done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // event store with registered read straight into the result register;
   // a pop and a push never come from the same request
   always_ff @(posedge clock) begin
      if (push_en) begin
         event_slots[wr_ptr_ff] <= line_stat.code;
      end
      if (advance) begin
         if (is_pop) begin
            rsp_data_ff.result_kind <= RESULT_POP;
            rsp_data_ff.event_code  <= empty ? CODE_NONE : event_slots[rd_ptr_ff];
            rsp_data_ff.taken       <= !empty;
         end else begin
            rsp_data_ff.result_kind <= RESULT_LINE;
            rsp_data_ff.event_code  <= line_stat.code;
            rsp_data_ff.taken       <= push_en;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "serial_command_matcher_event_fifo_macros.svh"

   `SCM_ASSERT_NEXT(a_empty_pop, advance && is_pop && empty,
      rsp_data_ff.event_code == CODE_NONE && !rsp_data_ff.taken,
      "pop of empty ring returned an event")
   `SCM_ASSERT_NEXT(a_push_moves, push_en,
      wr_ptr_ff != $past(wr_ptr_ff) && rd_ptr_ff == $past(rd_ptr_ff),
      "push did not move only the write pointer")
   `SCM_ASSERT_NOW(a_taken_code,
      rsp_valid_ff && rsp_data_ff.result_kind == RESULT_LINE && rsp_data_ff.taken,
      rsp_data_ff.event_code != CODE_NONE, "queued line result without an event code")
   `SCM_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_ready, !advance,
      "stage advanced over a held result")

endmodule

/* hw/rtl/scm_line.sv */
module scm_line
   import scm_pkg::*;
#(
   parameter int LINE_SLOTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output line_status_type status
);

   localparam int PW = $clog2(LINE_SLOTS);

   logic [PW-1:0]         pos_ff, pos_in, pos_next;
   logic [WORD_COUNT-1:0] match_ff, match_in, match_next;
   logic                  overflow;

   assign overflow = (pos_ff == PW'(LINE_SLOTS - 1));
   assign pos_next = pos_ff + PW'(1);

   always_comb begin
      for (int w = 0; w < WORD_COUNT; w++) begin
         match_next[w] = match_ff[w] && (pos_ff < PW'(WORD_LEN[w]))
                         && (word_char(2'(w), pos_ff[3:0]) == rx_byte);
      end
   end

   // Lowest word index wins
   always_comb begin
      status.done = !overflow && (rx_byte == LINE_END);
      status.code = CODE_NONE;
      for (int w = WORD_COUNT - 1; w >= 0; w--) begin
         if (match_next[w] && (pos_next == PW'(WORD_LEN[w]))) begin
            status.code = WORD_CODE[w];
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      match_in = match_ff;
      if (step) begin
         if (overflow || status.done) begin
            pos_in   = '0;
            match_in = '1;
         end else begin
            pos_in   = pos_next;
            match_in = match_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= '1;
      end else begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
      end
   end

endmodule

/* bench/serial_command_matcher_event_fifo_tb.sv */
`timescale 1ns / 1ps

module serial_command_matcher_event_fifo_tb;
   import scm_pkg::*;

   localparam int LINE_SLOTS      = 64;
   localparam int QUEUE_SLOTS     = 10;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int RESET_CYCLES    = 6;
   // Nothing accepted on either channel for this long means the block is stuck.
   // The longest legal quiet stretch comes from the receiver hold-off.
   localparam int IDLE_LIMIT      = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   // Leave margin after the last predicted answer for stray late answers.
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_REPORTS     = 40;

   localparam logic [2:0] COMMAND_EVENT [4] = '{CODE_UART, CODE_LCD, CODE_TEMP, CODE_FREQ};

   // Receiver stall patterns.
   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_MOSTLY,
      STALL_SOMETIMES
   } stall_mode_type;

   // Ways of spoiling a command word.
   typedef enum int {
      FAULT_SWAP,
      FAULT_DROP,
      FAULT_LEAD,
      FAULT_SHORT
   } fault_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   serial_command_matcher_event_fifo #(
      .LINE_SLOTS  (LINE_SLOTS),
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: line position, per-word match flags, event ring.
   // Starts at its post-reset value; reset is applied only once.
   // ------------------------------------------------------------------
   logic [5:0] line_pos    = '0;
   logic [3:0] still_match = 4'hF;
   logic [2:0] event_store [QUEUE_SLOTS];
   logic [3:0] rd_ptr      = '0;
   logic [3:0] wr_ptr      = '0;

   req_payload_type requests_to_send [$];   // stimulus not yet offered
   rsp_payload_type answers_due [$];        // predicted answers, oldest first

   int fail_count   = 0;
   int report_count = 0;

   function automatic string command_word(input int w);
      case (w)
         0:       return "task: uart.";
         1:       return "task: lcd.";
         2:       return "task: temp.";
         default: return "task: fre.";
      endcase
   endfunction

   function automatic logic [3:0] ring_next(input logic [3:0] p);
      return (p == 4'(QUEUE_SLOTS - 1)) ? 4'd0 : p + 4'd1;
   endfunction

   // Works out the answer (if any) to one accepted request and updates the
   // predicted line and ring state.
   task automatic step_matcher(input req_payload_type r);
      rsp_payload_type ans;
      string           word;
      ans = '0;
      if (r.kind == KIND_POP) begin
         ans.result_kind = RESULT_POP;
         ans.event_code  = CODE_NONE;
         if (rd_ptr != wr_ptr) begin
            ans.event_code = event_store[rd_ptr];
            ans.taken      = 1'b1;
            rd_ptr         = ring_next(rd_ptr);
         end
         answers_due.push_back(ans);
      end else if (line_pos >= 6'(LINE_SLOTS - 1)) begin
         // line overflow: byte dropped, even a full stop, and no answer
         line_pos    = '0;
         still_match = 4'hF;
      end else begin
         for (int w = 0; w < 4; w++) begin
            word = command_word(w);
            if (!(line_pos < word.len() && word[line_pos] == r.rx_byte)) begin
               still_match[w] = 1'b0;
            end
         end
         line_pos = line_pos + 6'd1;
         if (r.rx_byte == LINE_END) begin
            ans.result_kind = RESULT_LINE;
            ans.event_code  = CODE_NONE;
            for (int w = 3; w >= 0; w--) begin
               word = command_word(w);
               if (still_match[w] && line_pos == 6'(word.len())) begin
                  ans.event_code = COMMAND_EVENT[w];
               end
            end
            // full ring drops the event but still names the word
            if (ans.event_code != CODE_NONE && ring_next(wr_ptr) != rd_ptr) begin
               event_store[wr_ptr] = ans.event_code;
               wr_ptr              = ring_next(wr_ptr);
               ans.taken           = 1'b1;
            end
            line_pos    = '0;
            still_match = 4'hF;
            answers_due.push_back(ans);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_request(input logic kind, input logic [7:0] b);
      req_payload_type r;
      r.kind    = kind;
      r.rx_byte = b;
      requests_to_send.push_back(r);
   endtask

   // Sends a word, now and then slipping a pop request in ahead of a character.
   task automatic queue_text(input string s, input int pop_odds);
      for (int i = 0; i < s.len(); i++) begin
         if (pop_odds != 0 && $urandom_range(pop_odds - 1) == 0) begin
            queue_request(KIND_POP, 8'($urandom));
         end
         queue_request(KIND_BYTE, s[i]);
      end
   endtask

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == LINE_END) begin
         b = ~b;
      end
      return b;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers queued requests in bursts with random gaps between.
   // Predicts each request at the edge it is accepted.
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      req_payload_type next_req;
      logic            load;
      next_req = '0;
      load     = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            step_matcher(req_data);
         end
         // valid is only changed once the current request is gone
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (requests_to_send.size() != 0) begin
               load     = 1'b1;
               next_req = requests_to_send.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_valid <= load;
            if (load) begin
               req_data <= next_req;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks every accepted answer against the oldest prediction.
   // Receiver stalls follow a changing pattern, plus two long hold-offs
   // that let the block back up and drop req_ready.
   // ------------------------------------------------------------------
   stall_mode_type stall_mode  = STALL_NONE;
   int             mode_left   = 0;
   int             hold_left   = 0;
   int             holds_done  = 0;
   int             answers_got = 0;

   always @(posedge clock) begin : check_answers
      rsp_payload_type want;
      logic            ready_next;
      ready_next = 1'b1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_got++;
            if (answers_due.size() == 0) begin
               fail_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("%0t: unexpected answer, expected none, %s %0d code %0d taken %0d",
                           $time, "actual kind", rsp_data.result_kind,
                           rsp_data.event_code, rsp_data.taken);
               end
            end else begin
               want = answers_due.pop_front();
               check_field("result_kind", want.result_kind, rsp_data.result_kind);
               check_field("event_code", want.event_code, rsp_data.event_code);
               check_field("taken", want.taken, rsp_data.taken);
            end
         end

         if (hold_left == 0 &&
             ((holds_done == 0 && answers_got >= 10) ||
              (holds_done == 1 && answers_got >= 60))) begin
            hold_left = HOLD_OFF_CYCLES;
            holds_done++;
         end

         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(3));
               mode_left  = $urandom_range(8, 64);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:   ready_next = 1'b1;
               STALL_HALF:   ready_next = $urandom_range(1);
               STALL_MOSTLY: ready_next = ($urandom_range(3) == 0);
               default:      ready_next = ($urandom_range(3) != 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: quiet cycles on both channels.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus build, reset and end of run
   // ------------------------------------------------------------------
   initial begin : run
      int        choice;
      int        w;
      int        n;
      int        pos;
      int        total;
      fault_type fault;
      string     word;

      // Directed: pop on empty, junk lines, one good command and its pop, all-ones byte, bare full stop.
      queue_request(KIND_POP, 8'hFF);
      queue_request(KIND_BYTE, 8'h00);
      queue_request(KIND_BYTE, LINE_END);
      queue_text("task: fre.", 0);
      queue_request(KIND_POP, 8'h00);
      queue_request(KIND_BYTE, 8'hFF);
      queue_request(KIND_BYTE, LINE_END);
      queue_request(KIND_BYTE, LINE_END);   // bare full stop

      total = requests_to_send.size() + RANDOM_REQUESTS;
      while (requests_to_send.size() < total) begin
         choice = $urandom_range(99);
         w      = $urandom_range(3);
         if (choice < 30) begin
            // well-formed command, sometimes with pops mixed in
            queue_text(command_word(w), ($urandom_range(1) == 0) ? 0 : 8);
         end else if (choice < 45) begin
            // spoilt command
            word  = command_word(w);
            pos   = $urandom_range(word.len() - 2);
            fault = fault_type'($urandom_range(3));
            if (fault == FAULT_LEAD) begin
               queue_request(KIND_BYTE, filler_byte());
            end
            for (int i = 0; i < word.len(); i++) begin
               if (i == pos && fault == FAULT_SWAP) begin
                  queue_request(KIND_BYTE, 8'($urandom));
               end else if (i == pos && fault == FAULT_SHORT) begin
                  queue_request(KIND_BYTE, LINE_END);
                  break;
               end else if (!(i == pos && fault == FAULT_DROP)) begin
                  queue_request(KIND_BYTE, word[i]);
               end
            end
         end else if (choice < 70) begin
            // pops, now and then enough to drain the whole ring and more
            n = ($urandom_range(3) == 0) ? 12 : $urandom_range(1, 4);
            repeat (n) queue_request(KIND_POP, 8'($urandom));
         end else if (choice < 85) begin
            // noise bytes, full stop fairly likely
            n = $urandom_range(1, 6);
            repeat (n) begin
               queue_request(KIND_BYTE,
                             ($urandom_range(3) == 0) ? LINE_END : 8'($urandom));
            end
         end else if (choice < 96) begin
            // back-to-back commands to fill the ring
            repeat (3) queue_text(command_word($urandom_range(3)), 0);
         end else begin
            // long line around the overflow point, then a full stop or a word
            n = $urandom_range(LINE_SLOTS - 4, LINE_SLOTS + 2);
            repeat (n) queue_request(KIND_BYTE, filler_byte());
            if ($urandom_range(1) == 0) begin
               queue_request(KIND_BYTE, LINE_END);
            end else begin
               queue_text(command_word(w), 0);
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (requests_to_send.size() != 0 || req_valid) @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
